>>> hw/rtl/bal_pkg.sv
// Shared constants for the bounded array list: field widths, opcodes and
// status codes. No dependencies.
`default_nettype none

package bal_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int OPC_W  = 2;
  localparam int STAT_W = 2;
  localparam int CNTO_W = 5;

  localparam logic [OPC_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OPC_W-1:0] OP_DELETE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_AVERAGE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

>>> hw/rtl/bal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/bal_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; used by the bounded array list for the average.
`default_nettype none

module bal_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DEN_W:0] rem;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_new;
  logic           fits;

  always_comb begin
    rem_sh  = {rem[DEN_W-1:0], quo[NUM_W-1]};
    fits    = (rem_sh >= {1'b0, den_r});
    rem_new = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NUM_W);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= rem_new;
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bounded_array_list.sv
// Bounded ordered list of Q16.16 values with insert, delete and average.
// Insert shifts each entry from the position up one slot, then writes the item
// (append counts as pos = count); delete subtracts the entry from the sum and
// shifts each higher entry down; average runs the divider, one quotient bit a
// cycle. The next item is taken as the result is raised, even while it waits.
// Synchronous reset empties the list (count and sum); entry storage keeps
// its contents and needs no clearing pass.
`default_nettype none

module bounded_array_list
  import bal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DATA_W-1:0] item_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [STAT_W-1:0] status,
  output logic      [CNTO_W-1:0] entry_count,
  output logic      [DATA_W-1:0] mean_value
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int TOT_W = DATA_W + $clog2(CAPACITY);
  localparam int CMP_W = CNT_W + POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_SHW, S_DRD, S_DSUB, S_DCHK, S_DWR, S_DIV, S_FIN
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  count;
  logic [TOT_W-1:0]  total;
  logic [IDX_W-1:0]  at;
  logic [IDX_W-1:0]  ptr;
  logic [DATA_W-1:0] val_r;
  logic [STAT_W-1:0] status_r;
  logic [DATA_W-1:0] mean_r;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              div_start;
  logic              div_done;
  logic [TOT_W-1:0]  div_quo;
  logic [TOT_W-1:0]  total_mag;
  logic [TOT_W-1:0]  mean_full;

  logic              pos_last;
  logic              pos_nonneg;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic [CNT_W+CNTO_W-1:0] cnt_wide;
  logic              fin_go;

  assign in_stall   = (state != S_IDLE);
  assign pos_last   = (position == {POS_W{1'b1}});
  assign pos_nonneg = !position[POS_W-1];
  assign pos_x      = CMP_W'(position[POS_W-2:0]);
  assign cnt_x      = CMP_W'(count);
  assign cnt_wide   = (CNT_W + CNTO_W)'(count);
  assign fin_go     = (state == S_FIN) && (!out_valid || !out_stall);

  assign total_mag = total[TOT_W-1] ? (TOT_W'(0) - total) : total;
  assign mean_full = total[TOT_W-1] ? (TOT_W'(0) - div_quo) : div_quo;
  assign div_start = (state == S_IDLE) && in_valid && (opcode == OP_AVERAGE) &&
                     (count != '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = ram_rdata;
    ram_raddr = ptr;
    unique case (state)
      S_INS: begin
        if (ptr == at) begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
        end else begin
          ram_raddr = ptr - IDX_W'(1);
        end
      end
      S_SHW:   ram_we = 1'b1;
      S_DRD:   ram_raddr = at;
      S_DCHK:  ram_raddr = ptr + IDX_W'(1);
      S_DWR:   ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            val_r    <= item_value;
            mean_r   <= '0;
            status_r <= ST_OK;
            state    <= S_FIN;
            unique case (opcode)
              OP_INSERT: begin
                ptr <= IDX_W'(count);
                if (cnt_x >= CMP_W'(CAPACITY)) begin
                  status_r <= ST_FULL;
                end else if (pos_last) begin
                  at    <= IDX_W'(count);
                  state <= S_INS;
                end else if (pos_nonneg && pos_x <= cnt_x) begin
                  at    <= IDX_W'(pos_x);
                  state <= S_INS;
                end else begin
                  status_r <= ST_BADPOS;
                end
              end
              OP_DELETE: begin
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                end else if (pos_last) begin
                  at    <= IDX_W'(count - CNT_W'(1));
                  state <= S_DRD;
                end else if (pos_nonneg && pos_x < cnt_x) begin
                  at    <= IDX_W'(pos_x);
                  state <= S_DRD;
                end else begin
                  status_r <= ST_BADPOS;
                end
              end
              OP_AVERAGE: begin
                if (count == '0) begin
                  status_r <= ST_EMPTY;
                end else begin
                  state <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_INS: begin
          if (ptr == at) begin
            count <= count + CNT_W'(1);
            total <= total + TOT_W'($signed(val_r));
            state <= S_FIN;
          end else begin
            state <= S_SHW;
          end
        end
        S_SHW: begin
          // moved one entry up; step towards the insert slot
          ptr   <= ptr - IDX_W'(1);
          state <= S_INS;
        end
        S_DRD: begin
          ptr   <= at;
          state <= S_DSUB;
        end
        S_DSUB: begin
          total <= total - TOT_W'($signed(ram_rdata));
          state <= S_DCHK;
        end
        S_DCHK: begin
          if (CNT_W'(ptr) + CNT_W'(1) == count) begin
            count <= count - CNT_W'(1);
            state <= S_FIN;
          end else begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          ptr   <= ptr + IDX_W'(1);
          state <= S_DCHK;
        end
        S_DIV: begin
          if (div_done) begin
            mean_r <= mean_full[DATA_W-1:0];
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (fin_go) begin
            status      <= status_r;
            entry_count <= cnt_wide[CNTO_W-1:0];
            mean_value  <= mean_r;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bal_div #(
    .NUM_W (TOT_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (total_mag),
    .den   (count),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

`default_nettype wire
